[rtl/core/qte_pkg.sv]
// Shared types and constants for the quintic trajectory evaluator.
`timescale 1ns / 1ps

package qte_pkg;

	// input and coefficient formats
	localparam int TIME_W    = 16;   // unsigned Q4.12
	localparam int FRAC      = 12;   // fraction bits of the time sample
	localparam int COEF_W    = 32;   // signed Q16.16
	localparam int SCOEF_W   = 37;   // room for 20 * a5
	localparam int OUT_W     = 32;

	// Horner datapath
	localparam int ACC_W     = 54;   // |acc| < 2^52 for any input
	localparam int SPLIT     = 27;   // accumulator split for the two partial products
	localparam int PL_W      = SPLIT + TIME_W;
	localparam int PH_W      = ACC_W - SPLIT + TIME_W + 1;
	localparam int SUM_W     = ACC_W + FRAC;
	localparam int NSTEP     = 5;
	localparam int NLANE     = 3;

	// lanes
	localparam int LANE_POS  = 0;
	localparam int LANE_VEL  = 1;
	localparam int LANE_ACC  = 2;

	// rounding constant: half a result LSB, added before the time fraction bits are dropped
	localparam logic [FRAC-1:0] HALF = 12'h800;

	// saturation bounds
	localparam logic [OUT_W-1:0] OUT_MAX = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A5 = 3'd5;

	// three accumulators carried together, indexed by lane
	typedef logic [NLANE-1:0][ACC_W-1:0]   lanes_t;
	// addends of one Horner step, indexed by lane
	typedef logic [NLANE-1:0][SCOEF_W-1:0] step_coef_t;
	typedef logic [SCOEF_W-1:0]            scoef_t;

endpackage

[rtl/core/qte_coef_regs.sv]
// Coefficient registers and the scaled derivative coefficients for every Horner step.
`timescale 1ns / 1ps

module qte_coef_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [qte_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [qte_pkg::COEF_W-1:0]      wr_data,
	output qte_pkg::scoef_t                 lead_coef,
	output qte_pkg::step_coef_t             step_coef [qte_pkg::NSTEP]
);

	qte_pkg::scoef_t     a5_q;
	qte_pkg::step_coef_t coef_q [qte_pkg::NSTEP];

	// sign-extended write data and its small multiples
	qte_pkg::scoef_t x1, x2, x3, x4, x5, x6, x12, x20;

	assign x1  = qte_pkg::SCOEF_W'($signed(wr_data));
	assign x2  = x1 << 1;
	assign x4  = x1 << 2;
	assign x3  = x2 + x1;
	assign x5  = x4 + x1;
	assign x6  = x4 + x2;
	assign x12 = (x1 << 3) + x4;
	assign x20 = (x1 << 4) + x4;

	// each coefficient lands in every lane and step that uses it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a5_q <= '0;
			for (int s = 0; s < qte_pkg::NSTEP; s++) begin
				coef_q[s] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				qte_pkg::REG_A5: begin
					a5_q <= x1;
					coef_q[0][qte_pkg::LANE_VEL] <= x5;
					coef_q[1][qte_pkg::LANE_ACC] <= x20;
				end
				qte_pkg::REG_A4: begin
					coef_q[0][qte_pkg::LANE_POS] <= x1;
					coef_q[1][qte_pkg::LANE_VEL] <= x4;
					coef_q[2][qte_pkg::LANE_ACC] <= x12;
				end
				qte_pkg::REG_A3: begin
					coef_q[1][qte_pkg::LANE_POS] <= x1;
					coef_q[2][qte_pkg::LANE_VEL] <= x3;
					coef_q[3][qte_pkg::LANE_ACC] <= x6;
				end
				qte_pkg::REG_A2: begin
					coef_q[2][qte_pkg::LANE_POS] <= x1;
					coef_q[3][qte_pkg::LANE_VEL] <= x2;
					coef_q[4][qte_pkg::LANE_ACC] <= x2;
				end
				qte_pkg::REG_A1: begin
					coef_q[3][qte_pkg::LANE_POS] <= x1;
					coef_q[4][qte_pkg::LANE_VEL] <= x1;
				end
				qte_pkg::REG_A0: begin
					coef_q[4][qte_pkg::LANE_POS] <= x1;
				end
				default: begin
				end
			endcase
		end
	end

	assign lead_coef = a5_q;
	always_comb begin
		for (int s = 0; s < qte_pkg::NSTEP; s++) begin
			step_coef[s] = coef_q[s];
		end
	end

	// a write of a5 sets the leading velocity addend to five times it
	a_vel_lead: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_index == qte_pkg::REG_A5
		|=> coef_q[0][qte_pkg::LANE_VEL] == (a5_q << 2) + a5_q)
		else $error("velocity lead coefficient not 5*a5");

endmodule

[rtl/core/qte_horner_step.sv]
// One Horner step for all three lanes: split multiply stage, then round-and-add stage.
`timescale 1ns / 1ps

module qte_horner_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qte_pkg::step_coef_t             coef,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  qte_pkg::lanes_t                 in_lanes,
	input  logic [qte_pkg::TIME_W-1:0]      in_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output qte_pkg::lanes_t                 out_lanes,
	output logic [qte_pkg::TIME_W-1:0]      out_time
);

	localparam int ACC_W = qte_pkg::ACC_W;
	localparam int SPLIT = qte_pkg::SPLIT;
	localparam int PL_W  = qte_pkg::PL_W;
	localparam int PH_W  = qte_pkg::PH_W;
	localparam int SUM_W = qte_pkg::SUM_W;
	localparam int NLANE = qte_pkg::NLANE;

	logic                            v_s1, v_s2;
	logic [qte_pkg::TIME_W-1:0]      t_s1, t_s2;
	logic [NLANE-1:0][PL_W-1:0]      pl_s1;
	logic [NLANE-1:0][PH_W-1:0]      ph_s1;
	qte_pkg::lanes_t                 lanes_s2;

	logic [NLANE-1:0][PL_W-1:0]      pl_w;
	logic [NLANE-1:0][PH_W-1:0]      ph_w;
	logic [NLANE-1:0][SUM_W-1:0]     sum_w;
	qte_pkg::lanes_t                 next_w;
	logic                            adv1, adv2;

	function automatic logic [SUM_W-SPLIT-1:0] ph_w_sel(input logic [PH_W-1:0] ph);
		ph_w_sel = ph[SUM_W-SPLIT-1:0];
	endfunction

	// stage advance: a stage moves when empty or when the next one takes its item
	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		// partial products: unsigned low part, signed high part
		assign pl_w[l] = PL_W'(in_lanes[l][SPLIT-1:0]) * PL_W'(in_time);
		assign ph_w[l] = PH_W'($signed(in_lanes[l][ACC_W-1:SPLIT]))
			* $signed({1'b0, in_time});

		// floor((acc*t + 2048) / 4096) + c as one three-operand add
		assign sum_w[l] = {ph_w_sel(ph_s1[l]), {SPLIT{1'b0}}}
			+ {{(SUM_W-PL_W){1'b0}}, pl_s1[l]}
			+ {{(ACC_W-qte_pkg::SCOEF_W){coef[l][qte_pkg::SCOEF_W-1]}}, coef[l], qte_pkg::HALF};
		assign next_w[l] = sum_w[l][SUM_W-1:qte_pkg::FRAC];
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			t_s1  <= in_time;
			pl_s1 <= pl_w;
			ph_s1 <= ph_w;
		end
	end

	// round-and-add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			t_s2     <= t_s1;
			lanes_s2 <= next_w;
		end
	end

	assign out_valid = v_s2;
	assign out_lanes = lanes_s2;
	assign out_time  = t_s2;

	// a held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(lanes_s2))
		else $error("Horner step result lost while stalled");

endmodule

[rtl/core/qte_sat_out.sv]
// Saturation of the three results to 32 bits and the output register.
`timescale 1ns / 1ps

module qte_sat_out (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  qte_pkg::lanes_t                 in_lanes,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3*qte_pkg::OUT_W-1:0]     out_data,
	output logic                            out_sat
);

	localparam int ACC_W = qte_pkg::ACC_W;
	localparam int OUT_W = qte_pkg::OUT_W;
	localparam int NLANE = qte_pkg::NLANE;

	logic                            v_q;
	logic [NLANE-1:0][OUT_W-1:0]     data_q;
	logic                            sat_q;

	logic [NLANE-1:0][OUT_W-1:0]     clip_w;
	logic [NLANE-1:0]                ovf_w;
	logic                            adv;

	assign adv      = !v_q || out_ready;
	assign in_ready = adv;

	// out of range when the bits above the result are not all sign copies
	for (genvar l = 0; l < NLANE; l++) begin : g_clip
		assign ovf_w[l] = !((&in_lanes[l][ACC_W-1:OUT_W-1]) || !(|in_lanes[l][ACC_W-1:OUT_W-1]));
		assign clip_w[l] = !ovf_w[l] ? in_lanes[l][OUT_W-1:0]
			: (in_lanes[l][ACC_W-1] ? qte_pkg::OUT_MIN : qte_pkg::OUT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_q <= clip_w;
			sat_q  <= |ovf_w;
		end
	end

	assign out_valid = v_q;
	assign out_data  = data_q;
	assign out_sat   = sat_q;

	// a flagged result has at least one field at a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && sat_q |->
			data_q[qte_pkg::LANE_POS] == qte_pkg::OUT_MAX
			|| data_q[qte_pkg::LANE_POS] == qte_pkg::OUT_MIN
			|| data_q[qte_pkg::LANE_VEL] == qte_pkg::OUT_MAX
			|| data_q[qte_pkg::LANE_VEL] == qte_pkg::OUT_MIN
			|| data_q[qte_pkg::LANE_ACC] == qte_pkg::OUT_MAX
			|| data_q[qte_pkg::LANE_ACC] == qte_pkg::OUT_MIN)
		else $error("saturation flag without a clipped field");

endmodule

[rtl/core/quintic_trajectory_eval.sv]
// Pipeline: five Horner steps of two stages each, then the saturation/output register.
// Throughput: one time sample per cycle; every stage only holds when the one after it
// is full and stalled, so the pipeline compresses bubbles.
// Reset: arst_n clears all valid bits and all six coefficients to zero.
// Time zero returns a0, a1 and 2*a2 (saturated).
`timescale 1ns / 1ps

module quintic_trajectory_eval (
	input  logic                                clk,
	input  logic                                arst_n,
	// time sample stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [qte_pkg::TIME_W-1:0]          s_axis_tdata,  // [15:0] time_sample
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [3*qte_pkg::OUT_W-1:0]         m_axis_tdata,  // [31:0] position,
	                                                           // [63:32] velocity,
	                                                           // [95:64] acceleration
	output logic                                m_axis_tuser,  // [0] saturated
	// coefficient writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qte_pkg::COEF_W-1:0]          cfg_data
);

	localparam int NSTEP = qte_pkg::NSTEP;
	localparam int ACC_W = qte_pkg::ACC_W;

	qte_pkg::scoef_t                    lead_coef;
	qte_pkg::step_coef_t                step_coef [NSTEP];

	logic [NSTEP:0]                     st_valid;
	logic [NSTEP:0]                     st_ready;
	qte_pkg::lanes_t                    st_lanes [NSTEP+1];
	logic [qte_pkg::TIME_W-1:0]         st_time  [NSTEP+1];

	// coefficient writes are always taken
	assign cfg_ready = 1'b1;

	qte_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.lead_coef (lead_coef),
		.step_coef (step_coef)
	);

	// seed: position starts at a5, the derivatives at zero
	assign st_valid[0]    = s_axis_tvalid;
	assign s_axis_tready  = st_ready[0];
	assign st_time[0]     = s_axis_tdata;
	always_comb begin
		st_lanes[0] = '0;
		st_lanes[0][qte_pkg::LANE_POS] =
			{{(ACC_W-qte_pkg::SCOEF_W){lead_coef[qte_pkg::SCOEF_W-1]}}, lead_coef};
	end

	// Horner chain
	for (genvar s = 0; s < NSTEP; s++) begin : g_step
		qte_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.coef      (step_coef[s]),
			.in_valid  (st_valid[s]),
			.in_ready  (st_ready[s]),
			.in_lanes  (st_lanes[s]),
			.in_time   (st_time[s]),
			.out_valid (st_valid[s+1]),
			.out_ready (st_ready[s+1]),
			.out_lanes (st_lanes[s+1]),
			.out_time  (st_time[s+1])
		);
	end

	qte_sat_out u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid[NSTEP]),
		.in_ready  (st_ready[NSTEP]),
		.in_lanes  (st_lanes[NSTEP]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_sat   (m_axis_tuser)
	);

	// with the sink ready every stage advances, so the input is never held off
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// the last step's time tag only changes on a transfer into it
	a_time_tag: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid[NSTEP] && !st_ready[NSTEP] |=> $stable(st_time[NSTEP]))
		else $error("time tag changed while stalled");

endmodule

[tb/sv/quintic_trajectory_eval_test.sv]
// Self-checking stream testbench for the quintic trajectory evaluator.
`timescale 1ns / 1ps

module quintic_trajectory_eval_test;

	localparam int     NCOEF      = 6;
	localparam int     IDLE_LIMIT = 500;   // cycles with no transfer on any channel
	localparam int     TAIL_WAIT  = 40;    // leave room for stray results
	localparam longint ROUND_HALF = 2048;  // 0.5 in Q4.12: half a result LSB, added before the shift
	localparam longint Q_MAX      = 64'sd2147483647;
	localparam longint Q_MIN      = -64'sd2147483648;
	localparam logic [qte_pkg::COEF_W-1:0] ONE_Q16 = 32'h0001_0000;

	// register indexes past the coefficients, writes there must be dropped
	localparam logic [qte_pkg::CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
	localparam logic [qte_pkg::CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

	typedef enum int {COEF_FULL, COEF_SMALL, COEF_EXTREME, COEF_CUBIC} coef_kind_t;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_STALLS} rx_mode_t;

	typedef struct packed {
		logic [qte_pkg::OUT_W-1:0] position;
		logic [qte_pkg::OUT_W-1:0] velocity;
		logic [qte_pkg::OUT_W-1:0] acceleration;
		logic                      saturated;
	} motion_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [qte_pkg::TIME_W-1:0]        s_axis_tdata = '0;  // [15:0] time_sample
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [3*qte_pkg::OUT_W-1:0]       m_axis_tdata;       // [31:0] position,
	                                                       // [63:32] velocity,
	                                                       // [95:64] acceleration
	logic                              m_axis_tuser;       // [0] saturated
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [qte_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [qte_pkg::COEF_W-1:0]        cfg_data = '0;

	// coefficient copy, sign-extended Q16.16
	longint coef_model [NCOEF];

	logic [qte_pkg::TIME_W-1:0] time_feed [$];
	motion_t                    pending_motion [$];

	int queued_cnt   = 0;
	int accepted_cnt = 0;
	int result_cnt   = 0;
	int sat_cnt      = 0;
	int coef_sets    = 0;
	int errors       = 0;
	int idle_cycles  = 0;

	// sender burst state
	bit time_taken = 1'b0;
	int burst_left = 1;
	int gap_left   = 0;

	// receiver stall state
	rx_mode_t rx_mode    = RX_OPEN;
	int       rx_cycle   = 0;
	int       stall_left = 0;

	motion_t      want_motion;
	logic [31:0]  got_f [4];
	logic [31:0]  want_f [4];
	string        field_name [4] = '{"position", "velocity", "acceleration", "saturated"};

	quintic_trajectory_eval uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one Horner multiply: round(x * t / 4096), half rounds toward +inf
	function automatic longint time_scale(input longint x, input longint whole,
	                                      input longint frac);
		return x * whole + ((x * frac + ROUND_HALF) >>> qte_pkg::FRAC);
	endfunction

	// position, velocity and acceleration at one time sample
	function automatic motion_t eval_motion(input logic [qte_pkg::TIME_W-1:0] t);
		longint  whole, frac;
		longint  lane [3];
		motion_t r;
		int      k;
		whole = longint'(t[qte_pkg::TIME_W-1:qte_pkg::FRAC]);
		frac  = longint'(t[qte_pkg::FRAC-1:0]);

		lane[qte_pkg::LANE_POS] = coef_model[5];
		for (k = 4; k >= 0; k--)
			lane[qte_pkg::LANE_POS] = time_scale(lane[qte_pkg::LANE_POS], whole, frac)
			                          + coef_model[k];

		lane[qte_pkg::LANE_VEL] = 5 * coef_model[5];
		for (k = 4; k >= 1; k--)
			lane[qte_pkg::LANE_VEL] = time_scale(lane[qte_pkg::LANE_VEL], whole, frac)
			                          + k * coef_model[k];

		lane[qte_pkg::LANE_ACC] = 20 * coef_model[5];
		for (k = 4; k >= 2; k--)
			lane[qte_pkg::LANE_ACC] = time_scale(lane[qte_pkg::LANE_ACC], whole, frac)
			                          + (k * (k - 1)) * coef_model[k];

		// clip each lane to 32 bits
		r.saturated = 1'b0;
		for (k = 0; k < qte_pkg::NLANE; k++) begin
			if (lane[k] > Q_MAX) begin
				lane[k] = Q_MAX;
				r.saturated = 1'b1;
			end else if (lane[k] < Q_MIN) begin
				lane[k] = Q_MIN;
				r.saturated = 1'b1;
			end
		end
		r.position     = lane[qte_pkg::LANE_POS][qte_pkg::OUT_W-1:0];
		r.velocity     = lane[qte_pkg::LANE_VEL][qte_pkg::OUT_W-1:0];
		r.acceleration = lane[qte_pkg::LANE_ACC][qte_pkg::OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [qte_pkg::COEF_W-1:0] pick_coef(input coef_kind_t kind,
	                                                         input int k);
		logic [qte_pkg::COEF_W-1:0] r;
		r = $urandom;
		case (kind)
			COEF_FULL: begin
				return r;
			end
			COEF_SMALL: begin
				// scaled so a trajectory over a few seconds stays in range
				return $signed(r) >>> (4 * k + 5);
			end
			COEF_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return qte_pkg::OUT_MAX;
					1: return qte_pkg::OUT_MIN;
					2: return '0;
					default: return r;
				endcase
			end
			default: begin
				if (k >= 4)
					return '0;
				return r[0] ? r : ($signed(r) >>> (4 * k + 5));
			end
		endcase
	endfunction

	function automatic logic [qte_pkg::TIME_W-1:0] rand_time();
		case ($urandom_range(0, 7))
			4, 5: return qte_pkg::TIME_W'($urandom_range(0, (1 << qte_pkg::FRAC) - 1));
			6: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h0001;
					2: return 16'h0800;
					3: return 16'h0fff;
					4: return 16'h8000;
					default: return 16'hffff;
				endcase
			end
			7: return qte_pkg::TIME_W'($urandom_range(0, 15) << qte_pkg::FRAC);
			default: return qte_pkg::TIME_W'($urandom);
		endcase
	endfunction

	// one register write, the model follows at the transfer
	task automatic write_reg(input logic [qte_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [qte_pkg::COEF_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= qte_pkg::REG_A5)
			coef_model[idx] = longint'($signed(d));
	endtask

	// full coefficient set, then a write to an unused index that must be ignored
	task automatic load_coefs(input logic [NCOEF-1:0][qte_pkg::COEF_W-1:0] c);
		write_reg(qte_pkg::REG_A0, c[0]);
		write_reg(qte_pkg::REG_A1, c[1]);
		write_reg(qte_pkg::REG_A2, c[2]);
		write_reg(qte_pkg::REG_A3, c[3]);
		write_reg(qte_pkg::REG_A4, c[4]);
		write_reg(qte_pkg::REG_A5, c[5]);
		write_reg($urandom_range(0, 1) ? REG_SPARE0 : REG_SPARE1, $urandom);
		@(negedge clk);
		cfg_valid <= 1'b0;
		coef_sets++;
	endtask

	task automatic queue_time(input logic [qte_pkg::TIME_W-1:0] t);
		time_feed.push_back(t);
		queued_cnt++;
	endtask

	// hold off until every queued sample went in and its result came back
	task automatic drain();
		@(negedge clk);
		while (accepted_cnt != queued_cnt || result_cnt != accepted_cnt)
			@(negedge clk);
	endtask

	// input transfers: predict at acceptance
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			pending_motion.push_back(eval_motion(s_axis_tdata));
			accepted_cnt++;
			time_taken = 1'b1;
		end
	end

	// sender: bursts of random length, random gaps, some long runs without gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || time_taken) begin
			time_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (time_feed.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= time_feed.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					if ($urandom_range(0, 4) == 0) begin
						gap_left   = 0;
						burst_left = 64;
					end else begin
						gap_left   = $urandom_range(1, 10);
						burst_left = $urandom_range(1, 16);
					end
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall mode redrawn at random among open, random, fixed pattern and stall bursts
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:    m_axis_tready <= 1'b1;
			RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_PATTERN: m_axis_tready <= ((rx_cycle % 9) < 5);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(1, 24);
				end
			end
		endcase
	end

	// result transfers: compare with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_motion.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
				         m_axis_tuser);
				errors++;
			end else begin
				want_motion = pending_motion.pop_front();
				want_f[0] = want_motion.position;
				want_f[1] = want_motion.velocity;
				want_f[2] = want_motion.acceleration;
				want_f[3] = {31'b0, want_motion.saturated};
				got_f[0]  = m_axis_tdata[qte_pkg::OUT_W-1:0];
				got_f[1]  = m_axis_tdata[2*qte_pkg::OUT_W-1:qte_pkg::OUT_W];
				got_f[2]  = m_axis_tdata[3*qte_pkg::OUT_W-1:2*qte_pkg::OUT_W];
				got_f[3]  = {31'b0, m_axis_tuser};
				for (int i = 0; i < 4; i++) begin
					if (got_f[i] !== want_f[i]) begin
						$display("%0t: result %0d %s expected %h actual %h", $time,
						         result_cnt, field_name[i], want_f[i], got_f[i]);
						errors++;
					end
				end
				if (want_motion.saturated)
					sat_cnt++;
			end
			result_cnt++;
		end
	end

	// watchdog on all channels going quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("quintic_trajectory_eval_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [NCOEF-1:0][qte_pkg::COEF_W-1:0] c;
		coef_kind_t                            kind;
		int                                    n;

		for (int k = 0; k < NCOEF; k++)
			coef_model[k] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// coefficients straight out of reset are zero
		queue_time(16'h0000);
		queue_time(16'hffff);
		drain();

		// every coefficient 1.0
		load_coefs({NCOEF{ONE_Q16}});
		queue_time(16'h0000);
		queue_time(16'h1000);
		queue_time(16'h0800);
		queue_time(16'h0001);
		queue_time(16'hffff);
		drain();

		// exact half-LSB products round up, for both signs
		load_coefs({32'h0000_0001, {5{32'h0}}});
		queue_time(16'h0800);
		queue_time(16'h1800);
		drain();
		load_coefs({32'hffff_ffff, {5{32'h0}}});
		queue_time(16'h0800);
		queue_time(16'h1800);
		drain();

		// largest coefficients, saturation on all lanes
		load_coefs({NCOEF{qte_pkg::OUT_MAX}});
		queue_time(16'h0000);
		queue_time(16'h0001);
		queue_time(16'hffff);
		drain();
		load_coefs({NCOEF{qte_pkg::OUT_MIN}});
		queue_time(16'h0000);
		queue_time(16'h8000);
		queue_time(16'hffff);
		drain();

		// cubic setting; at time zero 2*a2 clips
		c = {64'h0, 32'(ONE_Q16 << 2), qte_pkg::OUT_MIN, 32'(-ONE_Q16), 32'(ONE_Q16 << 4)};
		load_coefs(c);
		queue_time(16'h0000);
		queue_time(rand_time());
		drain();

		// alternating signs
		load_coefs({qte_pkg::OUT_MIN, qte_pkg::OUT_MAX, qte_pkg::OUT_MIN,
		            qte_pkg::OUT_MAX, qte_pkg::OUT_MIN, qte_pkg::OUT_MAX});
		queue_time(16'hffff);
		queue_time(16'h5555);
		queue_time(16'haaaa);
		drain();

		// random coefficient sets, sender holds off between them
		for (int ph = 0; ph < 8; ph++) begin
			kind = coef_kind_t'(ph % 4);
			for (int k = 0; k < NCOEF; k++)
				c[k] = pick_coef(kind, k);
			load_coefs(c);
			n = $urandom_range(80, 110);
			repeat (n)
				queue_time(rand_time());
			drain();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_motion.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_motion.size());
			errors++;
		end

		$display("checked %0d time samples over %0d coefficient sets, %0d saturated",
		         result_cnt, coef_sets, sat_cnt);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("quintic_trajectory_eval_test: PASS");
		else
			$display("quintic_trajectory_eval_test: FAIL");
		$finish;
	end

endmodule

[quintic_trajectory_eval.f]
rtl/core/qte_pkg.sv
rtl/core/qte_coef_regs.sv
rtl/core/qte_horner_step.sv
rtl/core/qte_sat_out.sv
rtl/core/quintic_trajectory_eval.sv
tb/sv/quintic_trajectory_eval_test.sv
